// ===== hw/rtl/irsm_pkg.sv =====
// Shared types and constants for the integer range set match block.
package irsm_pkg;

  // Default number of intervals the table holds
  localparam int unsigned TableDepthDefault = 16;

  // Field widths
  localparam int unsigned BoundW  = 32;
  localparam int unsigned ActionW = 2;
  localparam int unsigned GroupW  = 4;

  // Stream data widths, padded to whole bytes
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 72;

  // Item kinds carried on the input tuser
  typedef enum logic [ActionW-1:0] {
    ACT_ADD   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_QUERY = 2'd2
  } action_e;

  // One stored interval
  typedef struct packed {
    logic signed [BoundW-1:0] hi;
    logic signed [BoundW-1:0] lo;
  } bound_pair_t;

endpackage

// ===== hw/rtl/irsm_table.sv =====
// Interval store: one write port and one registered read port.
module irsm_table #(
  parameter int unsigned Depth = irsm_pkg::TableDepthDefault,
  parameter int unsigned AddrW = 4
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  irsm_pkg::bound_pair_t wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output irsm_pkg::bound_pair_t rdata_o
);

  irsm_pkg::bound_pair_t mem_q [Depth];
  irsm_pkg::bound_pair_t rdata_q;

  // Write one interval
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read one interval, data registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/integer_range_set_match.sv =====
// Top level: interval table with add, clear and first-match query.
// Add, clear and unused kinds: the transfer moves the sequencer to its done state, which loads the result.
// Query: the sequencer scans the stored entries, one table read a cycle, until the first match or the last entry.
// The next item is taken once the result register has been loaded and the sequencer is back in idle.
// A stalled result holds the sequencer in its done state and keeps the input not ready.
// Reset (async, active low) empties the table; stored bounds stay undefined until written.
module integer_range_set_match #(
  parameter int unsigned TABLE_DEPTH = irsm_pkg::TableDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [31:0] range_low, [63:32] range_high, [95:64] query_value
  input  logic [irsm_pkg::InDataW-1:0]  s_axis_tdata_i,
  // [1:0] action
  input  logic [irsm_pkg::ActionW-1:0]  s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [0] status, [1] hit, [5:2] match_group, [6] is_empty,
  // [38:7] lowest_bound, [70:39] highest_bound, [71] zero
  output logic [irsm_pkg::OutDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned BW   = irsm_pkg::BoundW;
  localparam int unsigned GW   = irsm_pkg::GroupW;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] issue_q, issue_d;
  logic            pend_q, pend_d;
  logic [IdxW-1:0] pend_idx_q, pend_idx_d;
  logic            out_valid_q, out_valid_d;

  logic signed [BW-1:0] least_low_q, least_low_d;
  logic signed [BW-1:0] greatest_high_q, greatest_high_d;

  logic                 status_q, status_d;
  logic                 hit_q, hit_d;
  logic [IdxW-1:0]      grp_q, grp_d;
  logic signed [BW-1:0] qval_q;
  logic [irsm_pkg::OutDataW-1:0] out_data_q, out_data_d;

  logic in_xfer;
  logic full;
  logic tbl_we;
  logic tbl_re;
  logic entry_hit;
  logic [IdxW+GW-1:0] grp_ext;
  irsm_pkg::action_e     action;
  irsm_pkg::bound_pair_t wr_pair;
  irsm_pkg::bound_pair_t rd_pair;
  logic signed [BW-1:0] in_lo, in_hi;

  assign action  = irsm_pkg::action_e'(s_axis_tuser_i);
  assign in_lo   = s_axis_tdata_i[BW-1:0];
  assign in_hi   = s_axis_tdata_i[2*BW-1:BW];
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;
  assign full    = (count_q == CntW'(TABLE_DEPTH));

  assign wr_pair.lo = in_lo;
  assign wr_pair.hi = in_hi;
  assign tbl_we = in_xfer && (action == irsm_pkg::ACT_ADD) && !full;
  assign tbl_re = (state_q == S_SCAN) && (issue_q < count_q);

  irsm_table #(
    .Depth (TABLE_DEPTH),
    .AddrW (IdxW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (wr_pair),
    .re_i    (tbl_re),
    .raddr_i (issue_q[IdxW-1:0]),
    .rdata_o (rd_pair)
  );

  // Compare the query value against the interval read last cycle
  assign entry_hit = pend_q && (qval_q >= rd_pair.lo) && (qval_q <= rd_pair.hi);

  // Keep the low four bits of the matching index
  assign grp_ext = {{GW{1'b0}}, grp_q};

  // Sequencer and table summary
  always_comb begin
    state_d         = state_q;
    count_d         = count_q;
    issue_d         = issue_q;
    pend_d          = pend_q;
    pend_idx_d      = pend_idx_q;
    least_low_d     = least_low_q;
    greatest_high_d = greatest_high_q;
    status_d        = status_q;
    hit_d           = hit_q;
    grp_d           = grp_q;
    out_valid_d     = out_valid_q;
    out_data_d      = out_data_q;

    // Release the result on a downstream transfer
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          status_d = 1'b0;
          hit_d    = 1'b0;
          grp_d    = '0;
          issue_d  = '0;
          pend_d   = 1'b0;
          state_d  = S_DONE;
          case (action)
            irsm_pkg::ACT_ADD: begin
              if (full) begin
                status_d = 1'b1;
              end else begin
                count_d = count_q + 1'b1;
                if (count_q == '0) begin
                  least_low_d     = in_lo;
                  greatest_high_d = in_hi;
                end else begin
                  if (in_lo < least_low_q)     least_low_d     = in_lo;
                  if (in_hi > greatest_high_q) greatest_high_d = in_hi;
                end
              end
            end
            irsm_pkg::ACT_CLEAR: begin
              count_d         = '0;
              least_low_d     = '0;
              greatest_high_d = '0;
            end
            irsm_pkg::ACT_QUERY: begin
              state_d = S_SCAN;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (entry_hit) begin
          hit_d   = 1'b1;
          grp_d   = pend_idx_q;
          pend_d  = 1'b0;
          state_d = S_DONE;
        end else if (tbl_re) begin
          pend_d     = 1'b1;
          pend_idx_d = issue_q[IdxW-1:0];
          issue_d    = issue_q + 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // Load the output register once it is free
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          out_data_d[0]   = status_q;
          out_data_d[1]   = hit_q;
          out_data_d[5:2] = grp_ext[GW-1:0];
          out_data_d[6]   = (count_q == '0);
          if (count_q != '0) begin
            out_data_d[BW+6:7]      = least_low_q;
            out_data_d[2*BW+6:BW+7] = greatest_high_q;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      count_q         <= '0;
      issue_q         <= '0;
      pend_q          <= 1'b0;
      out_valid_q     <= 1'b0;
      least_low_q     <= '0;
      greatest_high_q <= '0;
    end else begin
      state_q         <= state_d;
      count_q         <= count_d;
      issue_q         <= issue_d;
      pend_q          <= pend_d;
      out_valid_q     <= out_valid_d;
      least_low_q     <= least_low_d;
      greatest_high_q <= greatest_high_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    status_q   <= status_d;
    hit_q      <= hit_d;
    grp_q      <= grp_d;
    out_data_q <= out_data_d;
    if (in_xfer) begin
      qval_q <= s_axis_tdata_i[3*BW-1:2*BW];
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== hw/rtl/irsm_checker.sv =====
// Port-level checks for the integer range set match block, with its bind.
module irsm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [irsm_pkg::OutDataW-1:0] m_axis_tdata_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // One item at a time: busy right after an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while busy");

  // Empty table reports zero bounds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[6] |->
      (m_axis_tdata_o[38:7] == '0) && (m_axis_tdata_o[70:39] == '0))
    else $error("empty table with non-zero bounds");

  // No hit means group zero; a dropped add never hits and never reports an empty table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[1] |-> (m_axis_tdata_o[5:2] == '0))
    else $error("group set without hit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] |-> !m_axis_tdata_o[1] && !m_axis_tdata_o[6])
    else $error("dropped add reported with hit or empty table");

endmodule

bind integer_range_set_match irsm_checker u_irsm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ===== sim/integer_range_set_match_test.sv =====
// Testbench for integer_range_set_match: directed table, random items, predictor check.
`timescale 1ns / 1ps

module integer_range_set_match_test;
  import irsm_pkg::*;

  localparam int unsigned Depth      = TableDepthDefault;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned RandItems  = 1500;

  localparam logic [ActionW-1:0]       ActUnused = 2'd3;
  localparam logic signed [BoundW-1:0] BoundMin  = 32'sh8000_0000;
  localparam logic signed [BoundW-1:0] BoundMax  = 32'sh7fff_ffff;

  // One result, laid out as on the output tdata (status in bit 0)
  typedef struct packed {
    logic signed [BoundW-1:0] highest;
    logic signed [BoundW-1:0] lowest;
    logic                     is_empty;
    logic [GroupW-1:0]        group;
    logic                     hit;
    logic                     status;
  } match_result_t;

  // One row of the directed table
  typedef struct {
    logic [ActionW-1:0]       action;
    logic signed [BoundW-1:0] lo;
    logic signed [BoundW-1:0] hi;
    logic signed [BoundW-1:0] val;
    bit                       typed;
    match_result_t            want;
  } interval_row_t;

  logic                clk;
  logic                rst_n    = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata  = '0;
  logic [ActionW-1:0]  s_tuser  = ACT_ADD;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  // Mirror of the interval table
  logic signed [BoundW-1:0] table_lo [Depth];
  logic signed [BoundW-1:0] table_hi [Depth];
  int unsigned              table_count    = 0;
  logic signed [BoundW-1:0] table_least    = '0;
  logic signed [BoundW-1:0] table_greatest = '0;

  match_result_t results_due [$];
  interval_row_t directed_rows [$];
  int            outstanding = 0;
  int            mismatches  = 0;
  int            items_sent  = 0;
  int            results_seen = 0;
  int            n_adds = 0, n_dropped = 0, n_clears = 0, n_queries = 0;
  int            n_hits = 0, n_unused = 0, deepest_hit = 0;
  bit            idle_on  = 1'b1;
  int            hold_asks  = 0;
  int            holds_done = 0;

  integer_range_set_match u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one item to the mirror table and return its summary
  function automatic match_result_t apply_interval_item(input logic [ActionW-1:0] action,
                                                        input logic signed [BoundW-1:0] lo,
                                                        input logic signed [BoundW-1:0] hi,
                                                        input logic signed [BoundW-1:0] val);
    match_result_t r;
    int            i;
    r = '0;
    case (action)
      ACT_ADD: begin
        n_adds++;
        if (table_count >= Depth) begin
          r.status = 1'b1;
          n_dropped++;
        end else begin
          if (table_count == 0) begin
            table_least    = lo;
            table_greatest = hi;
          end else begin
            if (lo < table_least)    table_least    = lo;
            if (hi > table_greatest) table_greatest = hi;
          end
          table_lo[table_count] = lo;
          table_hi[table_count] = hi;
          table_count++;
        end
      end
      ACT_CLEAR: begin
        n_clears++;
        table_count    = 0;
        table_least    = '0;
        table_greatest = '0;
      end
      ACT_QUERY: begin
        n_queries++;
        // first match in insertion order wins
        for (i = 0; i < table_count && !r.hit; i++) begin
          if (val >= table_lo[i] && val <= table_hi[i]) begin
            r.hit   = 1'b1;
            r.group = i[GroupW-1:0];
            n_hits++;
            if (i > deepest_hit) deepest_hit = i;
          end
        end
      end
      default: n_unused++;
    endcase
    r.is_empty = (table_count == 0);
    if (table_count != 0) begin
      r.lowest  = table_least;
      r.highest = table_greatest;
    end
    return r;
  endfunction

  function automatic match_result_t outcome(input logic status, input logic hit,
                                            input logic [GroupW-1:0] group, input logic empty,
                                            input logic signed [BoundW-1:0] lowest,
                                            input logic signed [BoundW-1:0] highest);
    return '{highest, lowest, empty, group, hit, status};
  endfunction

  function automatic void add_row(input logic [ActionW-1:0] action,
                                  input logic signed [BoundW-1:0] lo,
                                  input logic signed [BoundW-1:0] hi,
                                  input logic signed [BoundW-1:0] val,
                                  input bit typed, input match_result_t want);
    interval_row_t row;
    row = '{action, lo, hi, val, typed, want};
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Offer one item, hold it until transfer, then record what is due back
  task automatic offer_item(input logic [ActionW-1:0] action,
                            input logic signed [BoundW-1:0] lo,
                            input logic signed [BoundW-1:0] hi,
                            input logic signed [BoundW-1:0] val,
                            input bit typed, input match_result_t want);
    match_result_t predicted;
    while (idle_on && $urandom_range(0, 99) < 37) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {val, hi, lo};
    s_tuser  <= action;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = apply_interval_item(action, lo, hi, val);
    results_due.insert(results_due.size(), typed ? want : predicted);
    outstanding++;
    items_sent++;
  endtask

  // Draw a random item, mostly adds and queries aimed at stored intervals
  task automatic draw_random_item(output logic [ActionW-1:0] action,
                                  output logic signed [BoundW-1:0] lo,
                                  output logic signed [BoundW-1:0] hi,
                                  output logic signed [BoundW-1:0] val);
    int unsigned pick;
    int unsigned idx;
    longint      span;
    lo   = $urandom;
    hi   = $urandom;
    val  = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      action = ACT_CLEAR;
    end else if (pick < 6) begin
      action = ActUnused;
    end else if (pick < 42) begin
      action = ACT_ADD;
      case ($urandom_range(0, 9))
        0: ;                                 // full-range bounds, often inverted
        1: hi = lo;                          // single value
        2: lo = BoundMin;
        3: hi = BoundMax;
        4: hi = lo - $urandom_range(1, 50);  // inverted, narrow
        default: begin
          // overlapping intervals near zero so the first match matters
          lo = $signed($urandom_range(0, 4000)) - 2000;
          hi = lo + $urandom_range(0, 300);
        end
      endcase
    end else begin
      action = ACT_QUERY;
      if (table_count != 0 && $urandom_range(0, 3) != 0) begin
        idx  = $urandom_range(0, table_count - 1);
        span = longint'(table_hi[idx]) - longint'(table_lo[idx]);
        case ($urandom_range(0, 3))
          0: val = table_lo[idx];
          1: val = table_hi[idx];
          2: val = table_lo[idx] - 1;
          default: begin
            if (span > 0) begin
              val = BoundW'(longint'(table_lo[idx]) + (longint'($urandom) % (span + 1)));
            end
          end
        endcase
      end
    end
  endtask

  // Result side: random back-pressure, plus a long hold-off for each request
  always begin
    @(posedge clk);
    if (holds_done < hold_asks) begin
      m_tready <= 1'b0;
      repeat (HoldCycles) @(posedge clk);
      holds_done++;
    end
    m_tready <= !(idle_on && $urandom_range(0, 99) < 37);
  end

  // Compare each result transfer with the oldest outstanding one
  always @(posedge clk) begin
    match_result_t got;
    match_result_t want;
    if (rst_n && m_tvalid && m_tready) begin
      got = match_result_t'(m_tdata[OutDataW-2:0]);
      results_seen++;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result %0d arrived with nothing outstanding", results_seen);
      end else begin
        want = results_due.pop_front();
        outstanding--;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: expected st=%0d hit=%0d grp=%0d empty=%0d lo=%0d hi=%0d",
                     results_seen, want.status, want.hit, want.group, want.is_empty,
                     want.lowest, want.highest);
            $display("           actual   st=%0d hit=%0d grp=%0d empty=%0d lo=%0d hi=%0d",
                     got.status, got.hit, got.group, got.is_empty, got.lowest, got.highest);
          end
        end
      end
    end
  end

  // Bound the run
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("timed out after %0d cycles with %0d results outstanding", CycleLimit, outstanding);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    logic [ActionW-1:0]       action;
    logic signed [BoundW-1:0] lo, hi, val;
    int                       k;

    // Empty table, extremes, inverted interval, fill to full, overflow, clear
    add_row(ACT_QUERY, '0, '0, '0, 1, outcome(0, 0, 0, 1, 0, 0));
    add_row(ActUnused, BoundMax, BoundMin, -1, 1, outcome(0, 0, 0, 1, 0, 0));
    add_row(ACT_ADD, BoundMin, BoundMin, BoundMax, 1, outcome(0, 0, 0, 0, BoundMin, BoundMin));
    add_row(ACT_QUERY, '0, '0, BoundMin, 1, outcome(0, 1, 0, 0, BoundMin, BoundMin));
    add_row(ACT_ADD, BoundMax, BoundMax, '0, 1, outcome(0, 0, 0, 0, BoundMin, BoundMax));
    add_row(ACT_QUERY, '0, '0, BoundMax, 1, outcome(0, 1, 1, 0, BoundMin, BoundMax));
    add_row(ACT_ADD, 100, -100, '0, 0, '0);
    add_row(ACT_QUERY, -1, -1, '0, 0, '0);
    add_row(ActUnused, -1, -1, -1, 0, '0);
    for (k = 3; k <= 14; k++) add_row(ACT_ADD, k * 1000, k * 1000 + 10, -1, 0, '0);
    add_row(ACT_ADD, -7, 7, '0, 0, '0);
    add_row(ACT_ADD, -1, 1, '0, 1, outcome(1, 0, 0, 0, BoundMin, BoundMax));
    add_row(ACT_QUERY, '0, '0, '0, 0, '0);
    add_row(ACT_QUERY, '0, '0, 14005, 0, '0);
    add_row(ACT_CLEAR, -1, -1, -1, 1, outcome(0, 0, 0, 1, 0, 0));
    add_row(ACT_QUERY, '0, '0, '0, 1, outcome(0, 0, 0, 1, 0, 0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i].action, directed_rows[i].lo, directed_rows[i].hi,
                 directed_rows[i].val, directed_rows[i].typed, directed_rows[i].want);
    end

    for (k = 0; k < RandItems; k++) begin
      // steady stretch with no idling on either side
      idle_on = !(k >= 500 && k < 800);
      if (k == 300 || k == 1200) hold_asks++;
      if (k == 1000) begin
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(posedge clk);
      end
      draw_random_item(action, lo, hi, val);
      offer_item(action, lo, hi, val, 0, '0);
    end
    s_tvalid <= 1'b0;

    // drain, then allow for the longest query latency
    while (outstanding != 0) @(posedge clk);
    repeat (Depth + 8) @(posedge clk);

    if (results_due.size() != 0) mismatches += results_due.size();
    $display("%0d items: %0d adds (%0d dropped on a full table), %0d clears, %0d unused codes",
             items_sent, n_adds, n_dropped, n_clears, n_unused);
    $display("%0d queries, %0d hits, deepest first match at entry %0d; %0d mismatches",
             n_queries, n_hits, deepest_hit, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
